### sv/glyph_atlas_channel_packer_macros.svh
// assertion macros shared by the glyph atlas channel packer rtl
`ifndef GLYPH_ATLAS_CHANNEL_PACKER_MACROS_SVH
`define GLYPH_ATLAS_CHANNEL_PACKER_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define GACP_ASSERT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked on clk outside reset
`define GACP_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### sv/gacp_pkg.sv
// shared constants and types for the glyph atlas channel packer
`default_nettype none

package gacp_pkg;

    localparam int NUM_CHANNELS       = 4;
    localparam int CHAN_W             = 2;
    localparam int GLYPH_W            = 10;
    localparam int PADDED_W           = 11;
    localparam int SLOT_W             = 16;
    localparam int CFG_W              = 8;
    localparam int CFG_INDEX_W        = 8;
    localparam int PASS_W             = 16;
    localparam int COORD_BITS_DEFAULT = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PAD_PIXELS    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SPREAD_PIXELS = CFG_INDEX_W'(1);

    localparam logic [CHAN_W-1:0] LAST_CHANNEL = CHAN_W'(NUM_CHANNELS - 1);
    localparam logic [PASS_W-1:0] PASS_MAX     = {PASS_W{1'b1}};

    typedef struct packed {
        logic [GLYPH_W-1:0] width;
        logic [GLYPH_W-1:0] height;
    } glyph_t;

    typedef struct packed {
        logic [PADDED_W-1:0] width;
        logic [PADDED_W-1:0] height;
    } padded_size_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   slot_channel;
        logic [SLOT_W-1:0]   slot_x;
        logic [SLOT_W-1:0]   slot_y;
        logic [PADDED_W-1:0] padded_width;
        logic [PADDED_W-1:0] padded_height;
        logic [SLOT_W-1:0]   atlas_width;
        logic [SLOT_W-1:0]   atlas_height;
    } placement_t;

endpackage

`default_nettype wire

### sv/gacp_cfg.sv
// border configuration registers and padded glyph size
`default_nettype none

module gacp_cfg
    import gacp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire glyph_t                 glyph,
    output      padded_size_t           size
);

    logic [CFG_W-1:0]    pad_reg;
    logic [CFG_W-1:0]    spread_reg;
    logic [CFG_W:0]      border_half;
    logic [PADDED_W-1:0] border;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg    <= '0;
            spread_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PAD_PIXELS:    pad_reg    <= cfg_data;
                REG_SPREAD_PIXELS: spread_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign border_half = {1'b0, pad_reg} + {1'b0, spread_reg};
    assign border      = {1'b0, border_half, 1'b0};

    assign size.width  = PADDED_W'(glyph.width) + border;
    assign size.height = PADDED_W'(glyph.height) + border;

endmodule

`default_nettype wire

### sv/gacp_placer.sv
// per-channel placement state and single-pass placement logic
`default_nettype none

`include "glyph_atlas_channel_packer_macros.svh"

module gacp_placer
    import gacp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire padded_size_t size,
    output      placement_t   result
);

    localparam int SUM_W = ((COORD_BITS > PADDED_W) ? COORD_BITS : PADDED_W) + 1;
    localparam int EXT_W = (COORD_BITS > SLOT_W) ? COORD_BITS : SLOT_W;
    localparam logic [SUM_W-1:0] COORD_MAX_S =
        {{(SUM_W-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

    logic [COORD_BITS-1:0] start_x_reg  [NUM_CHANNELS];
    logic [COORD_BITS-1:0] start_y_reg  [NUM_CHANNELS];
    logic [COORD_BITS-1:0] extent_x_reg [NUM_CHANNELS];
    logic [COORD_BITS-1:0] extent_y_reg [NUM_CHANNELS];
    logic [COORD_BITS-1:0] start_x_next [NUM_CHANNELS];
    logic [COORD_BITS-1:0] start_y_next [NUM_CHANNELS];
    logic [COORD_BITS-1:0] extent_x_next[NUM_CHANNELS];
    logic [COORD_BITS-1:0] extent_y_next[NUM_CHANNELS];

    logic                  grow_h_reg;
    logic                  grow_h_next;
    logic [PASS_W-1:0]     pass_length_reg;
    logic [PASS_W-1:0]     pass_length_next;
    logic [PASS_W-1:0]     pass_position_reg;
    logic [PASS_W-1:0]     pass_position_next;
    logic [CHAN_W-1:0]     chan_reg;
    logic [CHAN_W-1:0]     chan_next;
    logic [COORD_BITS-1:0] atlas_w_reg;
    logic [COORD_BITS-1:0] atlas_h_reg;
    logic [COORD_BITS-1:0] atlas_w_next;
    logic [COORD_BITS-1:0] atlas_h_next;

    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0] ext_x_new;
    logic [COORD_BITS-1:0] ext_y_new;
    logic [PASS_W:0]       pos_inc;
    logic                  last_in_rotation;
    logic                  flip;
    logic [EXT_W-1:0]      sx_ext;
    logic [EXT_W-1:0]      sy_ext;
    logic [EXT_W-1:0]      aw_ext;
    logic [EXT_W-1:0]      ah_ext;

    function automatic logic [COORD_BITS-1:0] sat_add(
        input logic [COORD_BITS-1:0] a,
        input logic [PADDED_W-1:0]   b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        return (s > COORD_MAX_S) ? {COORD_BITS{1'b1}} : s[COORD_BITS-1:0];
    endfunction

    assign sx        = start_x_reg[chan_reg];
    assign sy        = start_y_reg[chan_reg];
    assign end_x     = sat_add(sx, size.width);
    assign end_y     = sat_add(sy, size.height);
    assign ext_x_new = (extent_x_reg[chan_reg] > end_x) ? extent_x_reg[chan_reg] : end_x;
    assign ext_y_new = (extent_y_reg[chan_reg] > end_y) ? extent_y_reg[chan_reg] : end_y;

    assign atlas_w_next = (atlas_w_reg > ext_x_new) ? atlas_w_reg : ext_x_new;
    assign atlas_h_next = (atlas_h_reg > ext_y_new) ? atlas_h_reg : ext_y_new;

    assign last_in_rotation = (chan_reg == LAST_CHANNEL);
    assign pos_inc          = {1'b0, pass_position_reg} + (PASS_W+1)'(1);
    assign flip             = last_in_rotation && (pos_inc >= {1'b0, pass_length_reg});

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            start_x_next[i]  = start_x_reg[i];
            start_y_next[i]  = start_y_reg[i];
            extent_x_next[i] = extent_x_reg[i];
            extent_y_next[i] = extent_y_reg[i];
        end

        extent_x_next[chan_reg] = ext_x_new;
        extent_y_next[chan_reg] = ext_y_new;
        if (grow_h_reg)
        begin
            start_y_next[chan_reg] = end_y;
        end
        else
        begin
            start_x_next[chan_reg] = end_x;
        end

        // pass end: restart every channel along the new direction
        if (flip)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (!grow_h_reg)
                begin
                    start_x_next[i] = extent_x_next[i];
                    start_y_next[i] = '0;
                end
                else
                begin
                    start_x_next[i] = '0;
                    start_y_next[i] = extent_y_next[i];
                end
            end
        end
    end

    assign grow_h_next = flip ? !grow_h_reg : grow_h_reg;
    assign chan_next   = chan_reg + CHAN_W'(1);

    always_comb
    begin
        pass_position_next = pass_position_reg;
        pass_length_next   = pass_length_reg;
        if (last_in_rotation)
        begin
            pass_position_next = flip ? '0 : pos_inc[PASS_W-1:0];
        end
        if (flip && grow_h_reg && (pass_length_reg != PASS_MAX))
        begin
            pass_length_next = pass_length_reg + PASS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                start_x_reg[i]  <= '0;
                start_y_reg[i]  <= '0;
                extent_x_reg[i] <= '0;
                extent_y_reg[i] <= '0;
            end
            grow_h_reg        <= 1'b0;
            pass_length_reg   <= PASS_W'(1);
            pass_position_reg <= '0;
            chan_reg          <= '0;
            atlas_w_reg       <= '0;
            atlas_h_reg       <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                start_x_reg[i]  <= start_x_next[i];
                start_y_reg[i]  <= start_y_next[i];
                extent_x_reg[i] <= extent_x_next[i];
                extent_y_reg[i] <= extent_y_next[i];
            end
            grow_h_reg        <= grow_h_next;
            pass_length_reg   <= pass_length_next;
            pass_position_reg <= pass_position_next;
            chan_reg          <= chan_next;
            atlas_w_reg       <= atlas_w_next;
            atlas_h_reg       <= atlas_h_next;
        end
    end

    // coordinates leave through 16-bit fields
    assign sx_ext = EXT_W'(sx);
    assign sy_ext = EXT_W'(sy);
    assign aw_ext = EXT_W'(atlas_w_next);
    assign ah_ext = EXT_W'(atlas_h_next);

    assign result.slot_channel  = chan_reg;
    assign result.slot_x        = sx_ext[SLOT_W-1:0];
    assign result.slot_y        = sy_ext[SLOT_W-1:0];
    assign result.padded_width  = size.width;
    assign result.padded_height = size.height;
    assign result.atlas_width   = aw_ext[SLOT_W-1:0];
    assign result.atlas_height  = ah_ext[SLOT_W-1:0];

    `GACP_ASSERT_NEXT(a_chan_rotates, advance, chan_reg == CHAN_W'($past(chan_reg) + 1'b1), "channel did not rotate")
    `GACP_ASSERT(a_pos_below_len, 1'b1, pass_position_reg < pass_length_reg, "pass position out of range")
    `GACP_ASSERT(a_start_in_extent, 1'b1, (start_x_reg[0] <= extent_x_reg[0]) && (start_y_reg[0] <= extent_y_reg[0]), "start beyond extent")

endmodule

`default_nettype wire

### sv/glyph_atlas_channel_packer.sv
// top level of the glyph atlas channel packer
`default_nettype none

`include "glyph_atlas_channel_packer_macros.svh"

// Places one glyph per item into a four-channel atlas, rotating channels 0 to 3 and
// flipping between vertical and horizontal passes. One item is taken every cycle while
// in_stall is low: the item is registered, then, once the result register is empty or
// out_stall is low, one placement pass (border add, saturating coordinate add and extent
// compare on the current channel) loads the result register and updates the channel state.
// The user must write pad_pixels (index 0) and spread_pixels (index 1) only while no item
// is in flight; the block does not enforce this. Other indexes are ignored.
module glyph_atlas_channel_packer
    import gacp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire logic [GLYPH_W-1:0]     glyph_width,
    input  wire logic [GLYPH_W-1:0]     glyph_height,
    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      logic [CHAN_W-1:0]      slot_channel,
    output      logic [SLOT_W-1:0]      slot_x,
    output      logic [SLOT_W-1:0]      slot_y,
    output      logic [PADDED_W-1:0]    padded_width,
    output      logic [PADDED_W-1:0]    padded_height,
    output      logic [SLOT_W-1:0]      atlas_width,
    output      logic [SLOT_W-1:0]      atlas_height
);

    logic         s1_valid_reg;
    logic         s1_valid_next;
    glyph_t       glyph_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    placement_t   result_reg;
    placement_t   placement;
    padded_size_t size;
    logic         advance;
    logic         accept;

    gacp_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .glyph        (glyph_reg),
        .size         (size)
    );

    gacp_placer #(
        .COORD_BITS (COORD_BITS)
    ) u_placer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .size    (size),
        .result  (placement)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            glyph_reg.width  <= glyph_width;
            glyph_reg.height <= glyph_height;
        end
        if (advance)
        begin
            result_reg <= placement;
        end
    end

    assign out_valid     = out_valid_reg;
    assign slot_channel  = result_reg.slot_channel;
    assign slot_x        = result_reg.slot_x;
    assign slot_y        = result_reg.slot_y;
    assign padded_width  = result_reg.padded_width;
    assign padded_height = result_reg.padded_height;
    assign atlas_width   = result_reg.atlas_width;
    assign atlas_height  = result_reg.atlas_height;

    `GACP_ASSERT(a_stall_only_when_full, in_stall, s1_valid_reg && out_valid_reg, "stall with free stage")
    `GACP_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_reg, "accepted item lost")
    `GACP_ASSERT(a_result_from_stage, $rose(out_valid_reg), $past(s1_valid_reg), "result without item")

endmodule

`default_nettype wire
